// ===== hdl/sbcp_pkg.sv =====
// package: types, codes and constants of the serial bootloader command parser
`timescale 1ns / 1ps
package sbcp_pkg;

  localparam int unsigned AddrWidthDef = 32;
  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 32;
  localparam int unsigned MaxRes       = 7;
  localparam int unsigned ResCntWidth  = 3;

  typedef enum logic [2:0] {
    CFG_BOOT_START = 3'd0,
    CFG_BLOCK_SIZE = 3'd1,
    CFG_READ_BOOT  = 3'd2,
    CFG_SIGNATURE  = 3'd3,
    CFG_VERSION    = 3'd4,
    CFG_DEV_TYPE   = 3'd5,
    CFG_LOCK       = 3'd6,
    CFG_FUSE       = 3'd7
  } cfg_idx_e;

  typedef enum logic [2:0] {
    KIND_TX       = 3'd0,
    KIND_FILL     = 3'd1,
    KIND_PAGE_WR  = 3'd2,
    KIND_EE_WR    = 3'd3,
    KIND_FLASH_RD = 3'd4,
    KIND_EE_RD    = 3'd5,
    KIND_EXIT     = 3'd6,
    KIND_NONE     = 3'd7
  } kind_e;

  typedef enum logic [10:0] {
    PH_IDLE    = 11'b00000000001,
    PH_ADDR_HI = 11'b00000000010,
    PH_ADDR_LO = 11'b00000000100,
    PH_SKIP    = 11'b00000001000,
    PH_SIZE_HI = 11'b00000010000,
    PH_SIZE_LO = 11'b00000100000,
    PH_TYPE    = 11'b00001000000,
    PH_WR_LO   = 11'b00010000000,
    PH_WR_HI   = 11'b00100000000,
    PH_WR_EE   = 11'b01000000000,
    PH_RD_WAIT = 11'b10000000000
  } phase_e;

  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChYes   = 8'h59;
  localparam logic [7:0] ChQuery = 8'h3F;
  localparam logic [7:0] ChS     = 8'h53;
  localparam logic [7:0] ChF     = 8'h46;
  localparam logic [7:0] ChE     = 8'h45;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChB     = 8'h42;
  localparam logic [15:0] WordOnes = 16'hFFFF;

  // command bytes
  localparam logic [7:0] CmdEnterProg = 8'h50;
  localparam logic [7:0] CmdLeaveProg = 8'h4C;
  localparam logic [7:0] CmdSetType   = 8'h54;
  localparam logic [7:0] CmdSetLed    = 8'h78;
  localparam logic [7:0] CmdClrLed    = 8'h79;
  localparam logic [7:0] CmdExit      = 8'h45;
  localparam logic [7:0] CmdAutoInc   = 8'h61;
  localparam logic [7:0] CmdSetAddr   = 8'h41;
  localparam logic [7:0] CmdBlockSup  = 8'h62;
  localparam logic [7:0] CmdBlockWr   = 8'h42;
  localparam logic [7:0] CmdBlockRd   = 8'h67;
  localparam logic [7:0] CmdLock      = 8'h72;
  localparam logic [7:0] CmdFuseLo    = 8'h46;
  localparam logic [7:0] CmdFuseHi    = 8'h4E;
  localparam logic [7:0] CmdFuseExt   = 8'h51;
  localparam logic [7:0] CmdDevList   = 8'h74;
  localparam logic [7:0] CmdId        = 8'h53;
  localparam logic [7:0] CmdVersion   = 8'h56;
  localparam logic [7:0] CmdProgType  = 8'h70;
  localparam logic [7:0] CmdSig       = 8'h73;

  typedef logic [7:0] id_str_t [7];
  localparam id_str_t IdStr = '{8'h41, 8'h56, 8'h52, 8'h42, 8'h4F, 8'h4F, 8'h54};

  typedef struct packed {
    logic        op;
    logic [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  tx_byte;
    logic [31:0] mem_addr;
    logic [15:0] mem_data;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [31:0] boot_start_addr;
    logic [15:0] block_size;
    logic        read_boot_enable;
    logic [23:0] signature;
    logic [15:0] version;
    logic [7:0]  device_type;
    logic [7:0]  lock_bits;
    logic [23:0] fuse_bits;
  } cfg_t;

  // one queue entry: the result list of one input beat
  typedef struct packed {
    logic [ResCntWidth-1:0] cnt;
    logic [MaxRes-1:0][2:0]  kind;
    logic [MaxRes-1:0][7:0]  tx_byte;
    logic [31:0]             mem_addr;
    logic [31:0]             page_addr;   // address of a page write in the list
    logic [15:0]             mem_data;
  } batch_t;

endpackage

// ===== hdl/serial_bootloader_command_parser_core.sv =====
// top level: config registers, front parser and back result queue
//  channel | dir | handshake            | payload
//  in      | in  | in_valid / in_ready   | in_data (op, value)
//  out     | out | out_valid / out_ready | out_data (kind, tx_byte, mem_addr, mem_data, last)
//  cfg     | in  | cfg_valid / cfg_ready | cfg_index, cfg_data
// an input beat is parsed in its accept cycle; its results enter a two-entry queue
// results leave one per cycle while out_ready is high; an item yields 1..7 results at the
// output, and items with no result never enter the queue
// in_ready drops only while both queue entries hold results
// reset clears parser state and config to defaults; cfg_ready is always high
`timescale 1ns / 1ps
module serial_bootloader_command_parser_core #(
  parameter int unsigned AddrWidth = sbcp_pkg::AddrWidthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid,
  output logic in_ready,
  input  sbcp_pkg::in_item_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output sbcp_pkg::out_item_t out_data,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [sbcp_pkg::CfgIdxWidth-1:0] cfg_index,
  input  logic [sbcp_pkg::CfgDataWidth-1:0] cfg_data
);
  import sbcp_pkg::*;

  cfg_t cfg_q;
  logic qv, qr;
  batch_t qd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{boot_start_addr: 32'd28672, block_size: 16'd128, read_boot_enable: 1'b0,
                 signature: 24'd2004239, version: 16'd256, device_type: 8'd0,
                 lock_bits: 8'd255, fuse_bits: 24'hFFFFFF};
    end else if (cfg_valid) begin
      unique case (cfg_idx_e'(cfg_index))
        CFG_BOOT_START: cfg_q.boot_start_addr  <= cfg_data;
        CFG_BLOCK_SIZE: cfg_q.block_size       <= cfg_data[15:0];
        CFG_READ_BOOT:  cfg_q.read_boot_enable <= cfg_data[0];
        CFG_SIGNATURE:  cfg_q.signature        <= cfg_data[23:0];
        CFG_VERSION:    cfg_q.version          <= cfg_data[15:0];
        CFG_DEV_TYPE:   cfg_q.device_type      <= cfg_data[7:0];
        CFG_LOCK:       cfg_q.lock_bits        <= cfg_data[7:0];
        CFG_FUSE:       cfg_q.fuse_bits        <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  sbcp_front #(.AddrWidth(AddrWidth)) u_front (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .in_valid, .in_ready, .in_data,
    .q_valid_o(qv), .q_ready_i(qr), .q_data_o(qd)
  );

  sbcp_back u_back (
    .clk_i, .rst_ni, .q_valid_i(qv), .q_ready_o(qr), .q_data_i(qd),
    .out_valid, .out_ready, .out_data
  );

endmodule

// ===== hdl/sbcp_front.sv =====
// front part: protocol state and per-beat result list
`timescale 1ns / 1ps
module sbcp_front #(
  parameter int unsigned AddrWidth = sbcp_pkg::AddrWidthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sbcp_pkg::cfg_t    cfg_i,
  input  logic              in_valid,
  output logic              in_ready,
  input  sbcp_pkg::in_item_t in_data,
  output logic              q_valid_o,
  input  logic              q_ready_i,
  output sbcp_pkg::batch_t  q_data_o
);
  import sbcp_pkg::*;

  phase_e phase_q, phase_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [AddrWidth-1:0] addr_q, addr_d;
  logic [15:0] left_q, left_d;
  logic [AddrWidth-1:0] page_q, page_d;
  logic [7:0]  latch_q, latch_d;
  logic        ee_q, ee_d, halt_q, halt_d;

  batch_t b;
  logic [ResCntWidth-1:0] n;
  logic [7:0] v8;
  logic [15:0] rv;
  logic [AddrWidth-1:0] addr_p2, a16;
  logic [31:0] addr_ext;

  assign in_ready = q_ready_i;
  assign q_valid_o = in_valid;
  assign q_data_o  = b;
  assign v8 = in_data.value[7:0];
  assign addr_p2 = addr_q + AddrWidth'(2);
  assign a16 = AddrWidth'(addr_q[15:0]);
  assign addr_ext = 32'(addr_q);

  always_comb begin
    phase_d = phase_q; cmd_d = cmd_q; addr_d = addr_q; left_d = left_q;
    page_d = page_q; latch_d = latch_q; ee_d = ee_q; halt_d = halt_q;
    b = '0; n = '0; rv = in_data.value;
    for (int i = 0; i < MaxRes; i++) b.kind[i] = KIND_NONE;
    if (!halt_q && !in_data.op) begin
      unique case (phase_q)
        PH_IDLE: begin
          cmd_d = v8;
          unique case (v8)
            CmdEnterProg, CmdLeaveProg: begin
              b.kind[0] = KIND_TX; b.tx_byte[0] = ChCr; n = 3'd1;
            end
            CmdSetType, CmdSetLed, CmdClrLed: phase_d = PH_SKIP;
            CmdExit: begin
              b.kind[0] = KIND_TX; b.tx_byte[0] = ChCr; b.kind[1] = KIND_EXIT;
              n = 3'd2; halt_d = 1'b1;
            end
            CmdAutoInc: begin b.kind[0] = KIND_TX; b.tx_byte[0] = ChYes; n = 3'd1; end
            CmdSetAddr: phase_d = PH_ADDR_HI;
            CmdBlockSup: begin
              b.kind[0] = KIND_TX; b.kind[1] = KIND_TX; b.kind[2] = KIND_TX;
              b.tx_byte[0] = ChYes; b.tx_byte[1] = cfg_i.block_size[15:8];
              b.tx_byte[2] = cfg_i.block_size[7:0]; n = 3'd3;
            end
            CmdBlockWr, CmdBlockRd: phase_d = PH_SIZE_HI;
            CmdLock: begin
              b.kind[0] = KIND_TX; b.tx_byte[0] = cfg_i.lock_bits; n = 3'd1;
            end
            CmdFuseLo: begin
              b.kind[0] = KIND_TX; b.tx_byte[0] = cfg_i.fuse_bits[7:0]; n = 3'd1;
            end
            CmdFuseHi: begin
              b.kind[0] = KIND_TX; b.tx_byte[0] = cfg_i.fuse_bits[15:8]; n = 3'd1;
            end
            CmdFuseExt: begin
              b.kind[0] = KIND_TX; b.tx_byte[0] = cfg_i.fuse_bits[23:16]; n = 3'd1;
            end
            CmdDevList: begin
              b.kind[0] = KIND_TX; b.kind[1] = KIND_TX;
              b.tx_byte[0] = cfg_i.device_type; n = 3'd2;
            end
            CmdId: begin
              for (int i = 0; i < MaxRes; i++) begin
                b.kind[i] = KIND_TX; b.tx_byte[i] = IdStr[i];
              end
              n = 3'd7;
            end
            CmdVersion: begin
              b.kind[0] = KIND_TX; b.kind[1] = KIND_TX;
              b.tx_byte[0] = cfg_i.version[15:8] + ChZero;
              b.tx_byte[1] = cfg_i.version[7:0] + ChZero; n = 3'd2;
            end
            CmdProgType: begin b.kind[0] = KIND_TX; b.tx_byte[0] = ChS; n = 3'd1; end
            CmdSig: begin
              b.kind[0] = KIND_TX; b.kind[1] = KIND_TX; b.kind[2] = KIND_TX;
              b.tx_byte[0] = cfg_i.signature[7:0]; b.tx_byte[1] = cfg_i.signature[15:8];
              b.tx_byte[2] = cfg_i.signature[23:16]; n = 3'd3;
            end
            default: begin b.kind[0] = KIND_TX; b.tx_byte[0] = ChQuery; n = 3'd1; end
          endcase
        end
        PH_ADDR_HI: begin latch_d = v8; phase_d = PH_ADDR_LO; end
        PH_ADDR_LO: begin
          addr_d = AddrWidth'({latch_q, v8, 1'b0});
          b.kind[0] = KIND_TX; b.tx_byte[0] = ChCr; n = 3'd1; phase_d = PH_IDLE;
        end
        PH_SKIP: begin b.kind[0] = KIND_TX; b.tx_byte[0] = ChCr; n = 3'd1; phase_d = PH_IDLE; end
        PH_SIZE_HI: begin left_d = {v8, 8'h00}; phase_d = PH_SIZE_LO; end
        PH_SIZE_LO: begin left_d = left_q | {8'h00, v8}; phase_d = PH_TYPE; end
        PH_TYPE: begin
          phase_d = PH_IDLE;
          if (v8 == ChF) begin
            ee_d = 1'b0;
            if (cmd_q == CmdBlockWr) begin
              page_d = addr_q;
              if (left_q == '0) begin
                b.kind[0] = KIND_PAGE_WR;
                b.kind[1] = KIND_TX; b.tx_byte[1] = ChCr; n = 3'd2;
              end else phase_d = PH_WR_LO;
            end else if (left_q != '0) begin
              b.kind[0] = KIND_FLASH_RD; b.mem_addr = addr_ext; n = 3'd1;
              phase_d = PH_RD_WAIT;
            end
          end else if (v8 == ChE) begin
            ee_d = 1'b1; addr_d = a16;
            if (cmd_q == CmdBlockWr) begin
              if (left_q == '0) begin
                b.kind[0] = KIND_TX; b.tx_byte[0] = ChCr; n = 3'd1;
              end else phase_d = PH_WR_EE;
            end else if (left_q != '0) begin
              b.kind[0] = KIND_EE_RD; b.mem_addr = 32'(a16); n = 3'd1;
              phase_d = PH_RD_WAIT;
            end
          end else if (cmd_q == CmdBlockWr) begin
            b.kind[0] = KIND_TX; b.tx_byte[0] = ChCr; n = 3'd1;
          end
        end
        PH_WR_LO: begin
          latch_d = v8; left_d = left_q - 16'd1;
          if (left_q == 16'd1) begin
            b.kind[0] = KIND_FILL; b.mem_addr = addr_ext; b.mem_data = {8'hFF, v8};
            b.kind[1] = KIND_PAGE_WR; b.kind[2] = KIND_TX; b.tx_byte[2] = ChCr;
            n = 3'd3; addr_d = addr_p2; phase_d = PH_IDLE;
          end else phase_d = PH_WR_HI;
        end
        PH_WR_HI: begin
          b.kind[0] = KIND_FILL; b.mem_addr = addr_ext; b.mem_data = {v8, latch_q};
          addr_d = addr_p2; left_d = left_q - 16'd1; n = 3'd1; phase_d = PH_WR_LO;
          if (left_q == 16'd1) begin
            b.kind[1] = KIND_PAGE_WR; b.kind[2] = KIND_TX; b.tx_byte[2] = ChCr;
            n = 3'd3; phase_d = PH_IDLE;
          end
        end
        PH_WR_EE: begin
          b.kind[0] = KIND_EE_WR; b.mem_addr = addr_ext; b.mem_data = {8'h00, v8};
          addr_d = AddrWidth'(addr_q[15:0] + 16'd1); left_d = left_q - 16'd1; n = 3'd1;
          if (left_q == 16'd1) begin
            b.kind[1] = KIND_TX; b.tx_byte[1] = ChCr; n = 3'd2; phase_d = PH_IDLE;
          end
        end
        PH_RD_WAIT: ;
        default: ;
      endcase
    end else if (!halt_q && phase_q == PH_RD_WAIT) begin
      if (ee_q) begin
        b.kind[0] = KIND_TX; b.tx_byte[0] = rv[7:0];
        addr_d = AddrWidth'(addr_q[15:0] + 16'd1); left_d = left_q - 16'd1; n = 3'd1;
        if (left_q != 16'd1) begin
          b.kind[1] = KIND_EE_RD; b.mem_addr = 32'(addr_q[15:0] + 16'd1); n = 3'd2;
        end else phase_d = PH_IDLE;
      end else begin
        if (addr_ext >= cfg_i.boot_start_addr && !cfg_i.read_boot_enable) rv = WordOnes;
        b.kind[0] = KIND_TX; b.tx_byte[0] = rv[7:0];
        b.kind[1] = KIND_TX; b.tx_byte[1] = rv[15:8]; n = 3'd2;
        addr_d = addr_p2;
        left_d = (left_q >= 16'd2) ? left_q - 16'd2 : 16'd0;
        if (left_q > 16'd2) begin
          b.kind[2] = KIND_FLASH_RD; b.mem_addr = 32'(addr_p2); n = 3'd3;
        end else phase_d = PH_IDLE;
      end
    end
    // page write addresses carry the page start
    b.page_addr = 32'(page_d);
    b.cnt = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE; cmd_q <= '0; addr_q <= '0; left_q <= '0;
      page_q <= '0; latch_q <= '0; ee_q <= 1'b0; halt_q <= 1'b0;
    end else if (in_valid && in_ready) begin
      phase_q <= phase_d; cmd_q <= cmd_d; addr_q <= addr_d; left_q <= left_d;
      page_q <= page_d; latch_q <= latch_d; ee_q <= ee_d; halt_q <= halt_d;
    end
  end

endmodule

// ===== hdl/sbcp_back.sv =====
// back part: two-entry queue of result lists and result serializer
`timescale 1ns / 1ps
module sbcp_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  output logic               q_ready_o,
  input  sbcp_pkg::batch_t   q_data_i,
  output logic               out_valid,
  input  logic               out_ready,
  output sbcp_pkg::out_item_t out_data
);
  import sbcp_pkg::*;

  batch_t mem_q [2];
  logic   wp_q, rp_q;
  logic [1:0] cnt_q;
  logic [ResCntWidth-1:0] idx_q;
  batch_t head;
  logic push, pop, take;

  assign head = mem_q[rp_q];
  assign q_ready_o = (cnt_q != 2'd2);
  assign push = q_valid_i && q_ready_o && (q_data_i.cnt != '0);
  assign out_valid = (cnt_q != 2'd0);
  assign take = out_valid && out_ready;
  assign pop  = take && (idx_q == head.cnt - 3'd1);

  always_comb begin
    out_data = '0;
    out_data.kind = head.kind[idx_q];
    if (head.kind[idx_q] == KIND_TX) out_data.tx_byte = head.tx_byte[idx_q];
    if (head.kind[idx_q] == KIND_PAGE_WR) out_data.mem_addr = head.page_addr;
    else if (head.kind[idx_q] != KIND_TX && head.kind[idx_q] != KIND_EXIT)
      out_data.mem_addr = head.mem_addr;
    if (head.kind[idx_q] == KIND_FILL || head.kind[idx_q] == KIND_EE_WR)
      out_data.mem_data = head.mem_data;
    out_data.last = (idx_q == head.cnt - 3'd1);
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= q_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0; idx_q <= '0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) begin
        rp_q <= ~rp_q; idx_q <= '0;
      end else if (take) idx_q <= idx_q + 3'd1;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== hdl/sbcp_checker.sv =====
// port-level checker for the parser core, with its bind
`timescale 1ns / 1ps
module sbcp_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input sbcp_pkg::out_item_t out_data
);
  import sbcp_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("out beat dropped");
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_data.kind != KIND_NONE) else $error("bad kind");
  a_exit_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.kind == KIND_EXIT |-> out_data.last) else $error("exit not last");
  a_tx_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.kind == KIND_TX |-> out_data.mem_addr == '0) else $error("tx addr");
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> out_valid) else $error("stall without pending output");

endmodule

bind serial_bootloader_command_parser_core sbcp_checker u_sbcp_checker (
  .clk_i, .rst_ni, .in_valid, .in_ready, .out_valid, .out_ready, .out_data
);

// ===== bench/serial_bootloader_command_parser_core_tb.sv =====
// testbench: serial bootloader command parser core checked against a built-in predictor
`timescale 1ns / 1ps
module serial_bootloader_command_parser_core_tb;
  import sbcp_pkg::*;

  localparam int unsigned StallLimit = 5000;

  localparam logic [7:0] MemBad       = "Z";

  typedef logic [7:0] cmd_list_t [15];
  localparam cmd_list_t SimpleCmds = '{CmdEnterProg, CmdLeaveProg, CmdAutoInc, CmdBlockSup,
    CmdLock, ChF, CmdFuseHi, CmdFuseExt, CmdDevList, ChS, CmdVersion, CmdProgType, CmdSig,
    ChQuery, 8'h00};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxWidth-1:0] cfg_index = '0;
  logic [CfgDataWidth-1:0] cfg_data = '0;

  serial_bootloader_command_parser_core dut (
    .clk_i, .rst_ni, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  cfg_t        regs;
  phase_e      ph;
  logic [7:0]  cmd_code;
  logic [31:0] byte_addr;
  logic [15:0] left;
  logic [31:0] page_addr;
  logic [7:0]  lo_latch;
  bit          is_ee;
  bit          halted;

  out_item_t batch[$];
  out_item_t expected_q[$];
  int unsigned fails = 0;
  int unsigned beats_sent = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  bit exit_allowed = 0;

  function automatic void emit(kind_e k, logic [7:0] t, logic [31:0] a, logic [15:0] d);
    out_item_t r;
    r.kind = k;
    r.tx_byte = t;
    r.mem_addr = a;
    r.mem_data = d;
    r.last = 1'b0;
    if (batch.size() < MaxRes) batch.push_back(r);
  endfunction

  function automatic void send_tx(logic [7:0] b);
    emit(KIND_TX, b, '0, '0);
  endfunction

  function automatic void page_done();
    emit(KIND_PAGE_WR, '0, page_addr, '0);
    send_tx(ChCr);
    ph = PH_IDLE;
  endfunction

  function automatic void decode_cmd(logic [7:0] c);
    cmd_code = c;
    case (c)
      CmdEnterProg, CmdLeaveProg: send_tx(ChCr);
      CmdSetType, CmdSetLed, CmdClrLed: ph = PH_SKIP;
      ChE: begin
        send_tx(ChCr);
        emit(KIND_EXIT, '0, '0, '0);
        halted = 1;
      end
      CmdAutoInc: send_tx(ChYes);
      CmdSetAddr: ph = PH_ADDR_HI;
      CmdBlockSup: begin
        send_tx(ChYes);
        send_tx(regs.block_size[15:8]);
        send_tx(regs.block_size[7:0]);
      end
      ChB, CmdBlockRd: ph = PH_SIZE_HI;
      CmdLock: send_tx(regs.lock_bits);
      ChF: send_tx(regs.fuse_bits[7:0]);
      CmdFuseHi: send_tx(regs.fuse_bits[15:8]);
      CmdFuseExt: send_tx(regs.fuse_bits[23:16]);
      CmdDevList: begin
        send_tx(regs.device_type);
        send_tx(8'h00);
      end
      ChS: for (int i = 0; i < 7; i++) send_tx(IdStr[i]);
      CmdVersion: begin
        send_tx(regs.version[15:8] + ChZero);
        send_tx(regs.version[7:0] + ChZero);
      end
      CmdProgType: send_tx(ChS);
      CmdSig: begin
        send_tx(regs.signature[7:0]);
        send_tx(regs.signature[15:8]);
        send_tx(regs.signature[23:16]);
      end
      default: send_tx(ChQuery);
    endcase
  endfunction

  function automatic void select_memory(logic [7:0] t);
    ph = PH_IDLE;
    if (t == ChF) begin
      is_ee = 0;
      if (cmd_code == ChB) begin
        page_addr = byte_addr;
        if (left == 0) page_done();
        else ph = PH_WR_LO;
      end else if (left != 0) begin
        emit(KIND_FLASH_RD, '0, byte_addr, '0);
        ph = PH_RD_WAIT;
      end
    end else if (t == ChE) begin
      is_ee = 1;
      byte_addr = {16'h0, byte_addr[15:0]};
      if (cmd_code == ChB) begin
        if (left == 0) send_tx(ChCr);
        else ph = PH_WR_EE;
      end else if (left != 0) begin
        emit(KIND_EE_RD, '0, byte_addr, '0);
        ph = PH_RD_WAIT;
      end
    end else if (cmd_code == ChB) begin
      send_tx(ChCr);
    end
  endfunction

  function automatic void take_serial(logic [7:0] b);
    case (ph)
      PH_IDLE: decode_cmd(b);
      PH_ADDR_HI: begin
        lo_latch = b;
        ph = PH_ADDR_LO;
      end
      PH_ADDR_LO: begin
        byte_addr = {15'h0, lo_latch, b, 1'b0};
        send_tx(ChCr);
        ph = PH_IDLE;
      end
      PH_SKIP: begin
        send_tx(ChCr);
        ph = PH_IDLE;
      end
      PH_SIZE_HI: begin
        left = {b, 8'h00};
        ph = PH_SIZE_LO;
      end
      PH_SIZE_LO: begin
        left[7:0] = b;
        ph = PH_TYPE;
      end
      PH_TYPE: select_memory(b);
      PH_WR_LO: begin
        lo_latch = b;
        left = left - 16'd1;
        if (left == 0) begin
          // odd size: high byte of the last word padded with ones
          emit(KIND_FILL, '0, byte_addr, {8'hFF, lo_latch});
          byte_addr = byte_addr + 32'd2;
          page_done();
        end else begin
          ph = PH_WR_HI;
        end
      end
      PH_WR_HI: begin
        emit(KIND_FILL, '0, byte_addr, {b, lo_latch});
        byte_addr = byte_addr + 32'd2;
        left = left - 16'd1;
        if (left == 0) page_done();
        else ph = PH_WR_LO;
      end
      PH_WR_EE: begin
        emit(KIND_EE_WR, '0, byte_addr, {8'h00, b});
        byte_addr = {16'h0, byte_addr[15:0] + 16'd1};
        left = left - 16'd1;
        if (left == 0) begin
          send_tx(ChCr);
          ph = PH_IDLE;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void take_read(logic [15:0] v);
    if (ph != PH_RD_WAIT) return;
    if (is_ee) begin
      send_tx(v[7:0]);
      byte_addr = {16'h0, byte_addr[15:0] + 16'd1};
      left = left - 16'd1;
      if (left != 0) emit(KIND_EE_RD, '0, byte_addr, '0);
      else ph = PH_IDLE;
    end else begin
      if (byte_addr >= regs.boot_start_addr && !regs.read_boot_enable) v = WordOnes;
      send_tx(v[7:0]);
      send_tx(v[15:8]);
      byte_addr = byte_addr + 32'd2;
      left = (left >= 16'd2) ? left - 16'd2 : 16'd0;
      if (left != 0) emit(KIND_FLASH_RD, '0, byte_addr, '0);
      else ph = PH_IDLE;
    end
  endfunction

  function automatic void predict_beat(in_item_t it);
    batch.delete();
    if (halted) return;
    if (!it.op) take_serial(it.value[7:0]);
    else take_read(it.value);
    if (batch.size() > 0) batch[$].last = 1'b1;
    foreach (batch[i]) expected_q.push_back(batch[i]);
  endfunction

  task automatic send_beat(in_item_t it);
    if (!exit_allowed && !halted && ph == PH_IDLE && !it.op && it.value[7:0] == ChE)
      it.value[7:0] = CmdAutoInc;
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    predict_beat(it);
    beats_sent++;
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic ser(logic [7:0] b);
    send_beat('{op: 1'b0, value: {8'($urandom), b}});
  endtask

  task automatic rd_word(logic [15:0] v);
    send_beat('{op: 1'b1, value: v});
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    // items with no result never enter the queue; this wait is only a margin
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    case (idx)
      CFG_BOOT_START: regs.boot_start_addr = d;
      CFG_BLOCK_SIZE: regs.block_size = d[15:0];
      CFG_READ_BOOT:  regs.read_boot_enable = d[0];
      CFG_SIGNATURE:  regs.signature = d[23:0];
      CFG_VERSION:    regs.version = d[15:0];
      CFG_DEV_TYPE:   regs.device_type = d[7:0];
      CFG_LOCK:       regs.lock_bits = d[7:0];
      default:        regs.fuse_bits = d[23:0];
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_all_regs(logic [31:0] boot, logic [15:0] bsz, bit rbe, logic [23:0] sig,
                                logic [15:0] ver, logic [7:0] dt, logic [7:0] lk,
                                logic [23:0] fuse);
    write_reg(CFG_BOOT_START, boot);
    write_reg(CFG_BLOCK_SIZE, {16'h0, bsz});
    write_reg(CFG_READ_BOOT, {31'h0, rbe});
    write_reg(CFG_SIGNATURE, {8'h0, sig});
    write_reg(CFG_VERSION, {16'h0, ver});
    write_reg(CFG_DEV_TYPE, {24'h0, dt});
    write_reg(CFG_LOCK, {24'h0, lk});
    write_reg(CFG_FUSE, {8'h0, fuse});
  endtask

  task automatic block_cmd(logic [7:0] c, logic [15:0] size, logic [7:0] mem);
    ser(c);
    ser(size[15:8]);
    ser(size[7:0]);
    ser(mem);
  endtask

  task automatic query_all();
    foreach (SimpleCmds[i]) ser(SimpleCmds[i]);
  endtask

  task automatic test_commands();
    query_all();
    ser(CmdSetType); ser(8'h44);
    ser(CmdSetLed); ser(8'hFF);
    ser(CmdClrLed); ser(8'h00);
    ser(8'hFF);
    rd_word(16'hBEEF);                  // read data with nothing pending
  endtask

  task automatic test_block_write();
    ser(CmdSetAddr); ser(8'h00); ser(8'h10);
    block_cmd(ChB, 16'd3, ChF);         // odd byte count
    ser(8'h11); ser(8'h22); ser(8'h33);
    block_cmd(ChB, 16'd0, ChF);
    block_cmd(ChB, 16'd0, ChE);
    block_cmd(ChB, 16'd2, ChE);
    ser(8'hA5); ser(8'h5A);
    block_cmd(ChB, 16'd1, MemBad);
    ser(CmdSetAddr); ser(8'hFF); ser(8'hFF);
    block_cmd(ChB, 16'd2, ChE);         // eeprom address wraps at 16 bits
    ser(8'h01); ser(8'h02);
  endtask

  task automatic test_block_read();
    ser(CmdSetAddr); ser(8'h37); ser(8'hFF);
    block_cmd(CmdBlockRd, 16'd5, ChF);  // crosses the boot boundary
    rd_word(16'h1234);
    ser(CmdAutoInc);                    // serial byte while a read is pending
    rd_word(16'h5678);
    rd_word(16'h9ABC);
    block_cmd(CmdBlockRd, 16'd0, ChF);
    block_cmd(CmdBlockRd, 16'd1, MemBad);
    block_cmd(CmdBlockRd, 16'd2, ChE);
    rd_word(16'hFF80);
    rd_word(16'h007F);
  endtask

  task automatic test_config_extremes();
    drain();
    write_all_regs(32'hFFFF_FFFF, 16'hFFFF, 1'b1, 24'hFF_FFFF, 16'hFFFF, 8'hFF, 8'hFF,
                   24'hFF_FFFF);
    query_all();
    test_block_read();
    drain();
    write_all_regs(32'h0, 16'd1, 1'b0, 24'h0, 16'h0, 8'h0, 8'h0, 24'h0);
    query_all();
    test_block_read();
    drain();
    write_reg(CFG_READ_BOOT, 32'd1);
    test_block_read();
  endtask

  task automatic maybe_set_addr();
    if ($urandom_range(0, 1)) begin
      ser(CmdSetAddr);
      ser(8'($urandom));
      ser(8'($urandom));
    end
  endtask

  task automatic random_sequence();
    int unsigned r;
    int unsigned pick;
    logic [15:0] size;
    logic [7:0] mem;
    r = $urandom_range(0, 99);
    size = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 16)) : 16'($urandom_range(0, 5));
    pick = $urandom_range(0, 9);
    mem = (pick < 5) ? ChF : (pick < 9) ? ChE : 8'($urandom);
    if (r < 30) begin
      maybe_set_addr();
      block_cmd(CmdBlockRd, size, mem);
      while (ph == PH_RD_WAIT) begin
        if ($urandom_range(0, 9) == 0) ser(8'($urandom));
        rd_word(16'($urandom));
      end
    end else if (r < 55) begin
      maybe_set_addr();
      block_cmd(ChB, size, mem);
      while (ph == PH_WR_LO || ph == PH_WR_HI || ph == PH_WR_EE) begin
        if ($urandom_range(0, 49) == 0) break;   // broken sequence
        send_beat('{op: 1'b0, value: 16'($urandom)});
      end
    end else if (r < 65) begin
      ser(CmdSetAddr); ser(8'($urandom)); ser(8'($urandom));
    end else if (r < 72) begin
      pick = $urandom_range(0, 2);
      ser(pick == 0 ? CmdSetType : pick == 1 ? CmdSetLed : CmdClrLed);
      ser(8'($urandom));
    end else if (r < 85) begin
      ser(SimpleCmds[$urandom_range(0, 14)]);
    end else if (r < 92) begin
      ser(8'($urandom));
    end else begin
      send_beat('{op: 1'($urandom), value: 16'($urandom)});
    end
  endtask

  task automatic test_random(int unsigned idle, int unsigned stall, int unsigned count);
    int unsigned stop_at;
    drain();
    write_all_regs($urandom_range(0, 1) ? 32'($urandom_range(0, 32'h0002_0000)) : $urandom,
                   16'($urandom_range(1, 16'hFFFF)), 1'($urandom), 24'($urandom),
                   16'($urandom), 8'($urandom), 8'($urandom), 24'($urandom));
    idle_pct = idle;
    stall_pct = stall;
    stop_at = beats_sent + count;
    while (beats_sent < stop_at) random_sequence();
  endtask

  task automatic test_exit();
    drain();
    exit_allowed = 1;
    while (ph != PH_IDLE) begin
      if (ph == PH_RD_WAIT) rd_word(16'($urandom));
      else ser(8'($urandom));
    end
    ser(ChE);
    ser(CmdAutoInc);                    // ignored once halted
    rd_word(16'h1234);
    ser(CmdSig);
  endtask

  always @(posedge clk_i) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // result checker
  always @(posedge clk_i) begin
    out_item_t e;
    if (rst_ni && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: kind %0d tx %02h", out_data.kind, out_data.tx_byte);
        fails++;
      end else begin
        e = expected_q.pop_front();
        if (out_data.kind !== e.kind) begin
          $error("kind: expected %0d, got %0d", e.kind, out_data.kind);
          fails++;
        end
        if (out_data.tx_byte !== e.tx_byte) begin
          $error("tx_byte: expected %02h, got %02h", e.tx_byte, out_data.tx_byte);
          fails++;
        end
        if (out_data.mem_addr !== e.mem_addr) begin
          $error("mem_addr: expected %08h, got %08h", e.mem_addr, out_data.mem_addr);
          fails++;
        end
        if (out_data.mem_data !== e.mem_data) begin
          $error("mem_data: expected %04h, got %04h", e.mem_data, out_data.mem_data);
          fails++;
        end
        if (out_data.last !== e.last) begin
          $error("last: expected %0b, got %0b", e.last, out_data.last);
          fails++;
        end
      end
    end
  end

  // watchdog on cycles with no beat on any channel
  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("serial_bootloader_command_parser_core test failed");
      $finish;
    end
  end

  initial begin
    regs = '{boot_start_addr: 32'd28672, block_size: 16'd128, read_boot_enable: 1'b0,
             signature: 24'd2004239, version: 16'd256, device_type: 8'd0,
             lock_bits: 8'd255, fuse_bits: 24'hFF_FFFF};
    ph = PH_IDLE;
    cmd_code = '0;
    byte_addr = '0;
    left = '0;
    page_addr = '0;
    lo_latch = '0;
    is_ee = 0;
    halted = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_commands();
    test_block_write();
    test_block_read();
    test_config_extremes();
    test_random(0, 0, 60);
    test_random(77, 0, 60);
    test_random(0, 77, 60);
    test_random(25, 25, 60);
    test_exit();
    drain();
    repeat (20) @(posedge clk_i);
    if (fails == 0) begin
      $display("serial_bootloader_command_parser_core test passed");
    end else begin
      $display("serial_bootloader_command_parser_core test failed");
    end
    $finish;
  end

endmodule

// ===== serial_bootloader_command_parser_core.f =====
hdl/sbcp_pkg.sv
hdl/sbcp_front.sv
hdl/sbcp_back.sv
hdl/serial_bootloader_command_parser_core.sv
hdl/sbcp_checker.sv
bench/serial_bootloader_command_parser_core_tb.sv
